>>> src/tpq_pkg.sv
// Package for the tree path query block: sizes, item types and node entry layout.
package tpq_pkg;

   localparam int NODES      = 16384;
   localparam int LEVELS     = 14;
   localparam int NODE_BITS  = $clog2(NODES);
   localparam int LVL_BITS   = $clog2(LEVELS);
   localparam int ANC_DEPTH  = NODES << LVL_BITS;
   localparam int DEPTH_BITS = 14;
   localparam int DIST_BITS  = 34;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_DIST = 2'd1;
   localparam logic [1:0] OP_KTH  = 2'd2;

   typedef logic [NODE_BITS-1:0] node_type;
   typedef logic [LVL_BITS-1:0]  lvl_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [13:0] node_a;
      logic [13:0] node_b;
      logic [19:0] weight;
      logic [13:0] position;
   } req_type;

   typedef struct packed {
      logic [33:0] path_weight;
      logic [13:0] kth_node;
      logic        error;
   } rsp_type;

   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth;
      logic [DIST_BITS-1:0]  root_dist;
   } node_entry_type;

endpackage

>>> src/tree_path_query.sv
// Tree path query engine: binary-lifting ancestor table, depth/distance store and sequencer.
// Loads (operation 0) add a node under an already loaded parent and give no result. The
// ancestor memory and the node memory each have one registered read port, and every lifting
// level of a query chains an ancestor read into a depth read (or two ancestor reads while
// descending to the common ancestor). One item is worked on at a time; a new item is taken
// while a finished result still waits on the rsp channel. Node 0 is the virtual root and
// always reads as zero; there is no clearing pass after reset. Reading a node that was
// never loaded gives undefined results.
module tree_path_query (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tpq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tpq_pkg::rsp_type rsp_data
);

   typedef enum logic [18:0] {
      ST_IDLE  = 19'b0000000000000000001,
      ST_L_NRD = 19'b0000000000000000010,
      ST_L_NWR = 19'b0000000000000000100,
      ST_L_ARD = 19'b0000000000000001000,
      ST_L_AWR = 19'b0000000000000010000,
      ST_Q_RDA = 19'b0000000000000100000,
      ST_Q_RDB = 19'b0000000000001000000,
      ST_Q_SET = 19'b0000000000010000000,
      ST_C_ANC = 19'b0000000000100000000,
      ST_C_DEP = 19'b0000000001000000000,
      ST_C_FIN = 19'b0000000010000000000,
      ST_D_A   = 19'b0000000100000000000,
      ST_D_B   = 19'b0000001000000000000,
      ST_D_FIN = 19'b0000010000000000000,
      ST_D_UP  = 19'b0000100000000000000,
      ST_Q_RDL = 19'b0001000000000000000,
      ST_Q_LCA = 19'b0010000000000000000,
      ST_Q_KTH = 19'b0100000000000000000,
      ST_Q_OUT = 19'b1000000000000000000
   } state_type;

   localparam tpq_pkg::lvl_type LVL_TOP = tpq_pkg::LVL_BITS'(tpq_pkg::LEVELS - 1);

   // memories
   logic [tpq_pkg::NODE_BITS-1:0]  anc_mem [tpq_pkg::ANC_DEPTH];
   tpq_pkg::node_entry_type        node_mem [tpq_pkg::NODES];

   logic                           anc_we;
   tpq_pkg::node_type              anc_wnode;
   tpq_pkg::lvl_type               anc_wlvl;
   tpq_pkg::node_type              anc_wdata;
   tpq_pkg::node_type              anc_rnode;
   tpq_pkg::lvl_type               anc_rlvl;
   tpq_pkg::node_type              anc_rd_ff;
   logic                           anc_zero_ff;
   tpq_pkg::node_type              ad;

   logic                           node_we;
   tpq_pkg::node_type              node_wnode;
   tpq_pkg::node_entry_type        node_wdata;
   tpq_pkg::node_type              node_rnode;
   tpq_pkg::node_entry_type        node_rd_ff;
   logic                           node_zero_ff;
   tpq_pkg::node_entry_type        nd;

   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_mem[{anc_wnode, anc_wlvl}] <= anc_wdata;
      end
      anc_rd_ff   <= anc_mem[{anc_rnode, anc_rlvl}];
      anc_zero_ff <= (anc_rnode == '0);
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wnode] <= node_wdata;
      end
      node_rd_ff   <= node_mem[node_rnode];
      node_zero_ff <= (node_rnode == '0);
   end

   assign ad = anc_zero_ff ? '0 : anc_rd_ff;
   assign nd = node_zero_ff ? '0 : node_rd_ff;

   // sequencer state
   state_type                      state_ff, state_in;
   tpq_pkg::req_type               item_ff, item_in;
   tpq_pkg::node_type              wa_ff, wa_in;
   tpq_pkg::node_type              wb_ff, wb_in;
   tpq_pkg::node_type              y_ff, y_in;
   tpq_pkg::node_type              lca_ff, lca_in;
   tpq_pkg::lvl_type               lvl_ff, lvl_in;
   logic                           cmp_ff, cmp_in;
   logic                           kth_climb_ff, kth_climb_in;
   logic signed [16:0]             target_ff, target_in;
   logic [tpq_pkg::DEPTH_BITS-1:0] da_ff, da_in;
   logic [tpq_pkg::DEPTH_BITS-1:0] db_ff, db_in;
   logic [tpq_pkg::DEPTH_BITS-1:0] dl_ff, dl_in;
   logic [tpq_pkg::DIST_BITS-1:0]  sa_ff, sa_in;
   logic [tpq_pkg::DIST_BITS-1:0]  sb_ff, sb_in;
   tpq_pkg::rsp_type               res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   tpq_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   tpq_pkg::node_type              qa, qb;
   tpq_pkg::node_type              climb_x;
   tpq_pkg::node_type              desc_a, desc_b;
   logic signed [16:0]             count, up_side, kpos;

   assign qa = item_ff.node_a[tpq_pkg::NODE_BITS-1:0];
   assign qb = item_ff.node_b[tpq_pkg::NODE_BITS-1:0];

   always_comb begin
      climb_x = wa_ff;
      if (cmp_ff && ($signed({3'b000, nd.depth}) >= target_ff)) begin
         climb_x = y_ff;
      end
      desc_a = wa_ff;
      desc_b = wb_ff;
      if (cmp_ff && (y_ff != ad)) begin
         desc_a = y_ff;
         desc_b = ad;
      end
      kpos    = 17'($unsigned(item_ff.position));
      count   = 17'(da_ff) + 17'(db_ff) - (17'(dl_ff) <<< 1) + 17'sd1;
      up_side = 17'(da_ff) - 17'(dl_ff) + 17'sd1;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      wa_in        = wa_ff;
      wb_in        = wb_ff;
      y_in         = y_ff;
      lca_in       = lca_ff;
      lvl_in       = lvl_ff;
      cmp_in       = cmp_ff;
      kth_climb_in = kth_climb_ff;
      target_in    = target_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      dl_in        = dl_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      anc_we       = 1'b0;
      anc_wnode    = qa;
      anc_wlvl     = lvl_ff;
      anc_wdata    = ad;
      anc_rnode    = wa_ff;
      anc_rlvl     = lvl_ff;
      node_we      = 1'b0;
      node_wnode   = qa;
      node_wdata   = nd;
      node_rnode   = y_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               priority if (req_data.operation == tpq_pkg::OP_LOAD &&
                            req_data.node_a[tpq_pkg::NODE_BITS-1:0] != '0) begin
                  state_in = ST_L_NRD;
               end else if (req_data.operation == tpq_pkg::OP_DIST ||
                            req_data.operation == tpq_pkg::OP_KTH) begin
                  state_in = ST_Q_RDA;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_L_NRD: begin
            node_rnode = qb;
            state_in   = ST_L_NWR;
         end
         ST_L_NWR: begin
            node_we              = 1'b1;
            node_wdata.depth     = (nd.depth == '1) ? nd.depth : nd.depth + 1'b1;
            node_wdata.root_dist = nd.root_dist + tpq_pkg::DIST_BITS'(item_ff.weight);
            anc_we               = 1'b1;
            anc_wlvl             = '0;
            anc_wdata            = qb;
            wa_in                = qb;
            lvl_in               = tpq_pkg::LVL_BITS'(1);
            state_in             = ST_L_ARD;
         end
         ST_L_ARD: begin
            anc_rnode = wa_ff;
            anc_rlvl  = lvl_ff - 1'b1;
            state_in  = ST_L_AWR;
         end
         ST_L_AWR: begin
            anc_we    = 1'b1;
            anc_wlvl  = lvl_ff;
            anc_wdata = ad;
            wa_in     = ad;
            if (lvl_ff == LVL_TOP) begin
               state_in = ST_IDLE;
            end else begin
               lvl_in   = lvl_ff + 1'b1;
               state_in = ST_L_ARD;
            end
         end
         ST_Q_RDA: begin
            node_rnode = qa;
            state_in   = ST_Q_RDB;
         end
         ST_Q_RDB: begin
            da_in      = nd.depth;
            sa_in      = nd.root_dist;
            node_rnode = qb;
            state_in   = ST_Q_SET;
         end
         ST_Q_SET: begin
            db_in = nd.depth;
            sb_in = nd.root_dist;
            if (nd.depth > da_ff) begin
               wa_in     = qb;
               wb_in     = qa;
               target_in = 17'(da_ff);
            end else begin
               wa_in     = qa;
               wb_in     = qb;
               target_in = 17'(nd.depth);
            end
            kth_climb_in = 1'b0;
            lvl_in       = LVL_TOP;
            cmp_in       = 1'b0;
            state_in     = ST_C_ANC;
         end
         ST_C_ANC: begin
            wa_in     = climb_x;
            anc_rnode = climb_x;
            anc_rlvl  = lvl_ff;
            state_in  = ST_C_DEP;
         end
         ST_C_DEP: begin
            y_in       = ad;
            node_rnode = ad;
            cmp_in     = 1'b1;
            if (lvl_ff == '0) begin
               state_in = ST_C_FIN;
            end else begin
               lvl_in   = lvl_ff - 1'b1;
               state_in = ST_C_ANC;
            end
         end
         ST_C_FIN: begin
            wa_in = climb_x;
            priority if (kth_climb_ff) begin
               res_in.path_weight = '0;
               res_in.kth_node    = 14'(climb_x);
               res_in.error       = 1'b0;
               state_in           = ST_Q_OUT;
            end else if (climb_x == wb_ff) begin
               lca_in   = climb_x;
               state_in = ST_Q_RDL;
            end else begin
               lvl_in   = LVL_TOP;
               cmp_in   = 1'b0;
               state_in = ST_D_A;
            end
         end
         ST_D_A: begin
            wa_in     = desc_a;
            wb_in     = desc_b;
            anc_rnode = desc_a;
            anc_rlvl  = lvl_ff;
            state_in  = ST_D_B;
         end
         ST_D_B: begin
            y_in      = ad;
            anc_rnode = wb_ff;
            anc_rlvl  = lvl_ff;
            cmp_in    = 1'b1;
            if (lvl_ff == '0) begin
               state_in = ST_D_FIN;
            end else begin
               lvl_in   = lvl_ff - 1'b1;
               state_in = ST_D_A;
            end
         end
         ST_D_FIN: begin
            wa_in     = desc_a;
            wb_in     = desc_b;
            anc_rnode = desc_a;
            anc_rlvl  = '0;
            state_in  = ST_D_UP;
         end
         ST_D_UP: begin
            lca_in   = ad;
            state_in = ST_Q_RDL;
         end
         ST_Q_RDL: begin
            node_rnode = lca_ff;
            state_in   = ST_Q_LCA;
         end
         ST_Q_LCA: begin
            dl_in = nd.depth;
            if (item_ff.operation == tpq_pkg::OP_DIST) begin
               res_in.path_weight = sa_ff + sb_ff - (nd.root_dist << 1);
               res_in.kth_node    = '0;
               res_in.error       = 1'b0;
               state_in           = ST_Q_OUT;
            end else begin
               state_in = ST_Q_KTH;
            end
         end
         ST_Q_KTH: begin
            if (kpos == 17'sd0 || kpos > count) begin
               res_in.path_weight = '0;
               res_in.kth_node    = '0;
               res_in.error       = 1'b1;
               state_in           = ST_Q_OUT;
            end else begin
               if (up_side >= kpos) begin
                  wa_in     = qa;
                  target_in = 17'(da_ff) - kpos + 17'sd1;
               end else begin
                  wa_in     = qb;
                  target_in = 17'(dl_ff) + kpos - up_side;
               end
               kth_climb_in = 1'b1;
               lvl_in       = LVL_TOP;
               cmp_in       = 1'b0;
               state_in     = ST_C_ANC;
            end
         end
         ST_Q_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      wa_ff        <= wa_in;
      wb_ff        <= wb_in;
      y_ff         <= y_in;
      lca_ff       <= lca_in;
      lvl_ff       <= lvl_in;
      cmp_ff       <= cmp_in;
      kth_climb_ff <= kth_climb_in;
      target_ff    <= target_in;
      da_ff        <= da_in;
      db_ff        <= db_in;
      dl_ff        <= dl_in;
      sa_ff        <= sa_in;
      sb_ff        <= sb_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // virtual root is never overwritten
   a_anc_no_root: assert property (@(posedge clock) disable iff (reset)
      anc_we |-> anc_wnode != '0)
      else $error("ancestor write to node 0");

   a_node_no_root: assert property (@(posedge clock) disable iff (reset)
      node_we |-> node_wnode != '0)
      else $error("node write to node 0");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_Q_OUT))
      else $error("result raised outside output state");

   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C_ANC || state_ff == ST_D_A || state_ff == ST_L_AWR)
      |-> lvl_ff <= LVL_TOP)
      else $error("level counter out of range");

endmodule

>>> tb/tb_tree_path_query.sv
// Self-checking testbench for tree_path_query: random weighted forests, path queries, scoreboard.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 200;
   localparam logic [1:0] OP_SPARE = 2'd3;

   class path_scoreboard;
      logic [13:0]      anc[tpq_pkg::NODES][tpq_pkg::LEVELS];
      logic [13:0]      depth[tpq_pkg::NODES];
      logic [33:0]      root_dist[tpq_pkg::NODES];
      tpq_pkg::rsp_type pending[$];
      int               errors;
      int               checked;

      function new();
         for (int v = 0; v < tpq_pkg::NODES; v++) begin
            depth[v]     = '0;
            root_dist[v] = '0;
            for (int i = 0; i < tpq_pkg::LEVELS; i++) anc[v][i] = '0;
         end
         errors  = 0;
         checked = 0;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // highest ancestor of x whose depth is still at least target
      function logic [13:0] lift(logic [13:0] x, int target);
         logic [13:0] y;
         for (int i = tpq_pkg::LEVELS - 1; i >= 0; i--) begin
            y = anc[x][i];
            if (int'(depth[y]) >= target) x = y;
         end
         return x;
      endfunction

      function logic [13:0] meet(logic [13:0] a, logic [13:0] b);
         logic [13:0] t;
         if (depth[b] > depth[a]) begin
            t = a;
            a = b;
            b = t;
         end
         a = lift(a, int'(depth[b]));
         if (a == b) return a;
         for (int i = tpq_pkg::LEVELS - 1; i >= 0; i--) begin
            if (anc[a][i] != anc[b][i]) begin
               t = anc[a][i];
               b = anc[b][i];
               a = t;
            end
         end
         return anc[a][0];
      endfunction

      function int path_nodes(logic [13:0] a, logic [13:0] b);
         logic [13:0] l;
         l = meet(a, b);
         return int'(depth[a]) + int'(depth[b]) - 2 * int'(depth[l]) + 1;
      endfunction

      function void note(tpq_pkg::req_type r);
         tpq_pkg::rsp_type e;
         logic [13:0]      a, b, l;
         int               d, k, cnt, up_side, da, db, dl;
         a = r.node_a;
         b = r.node_b;
         e = '0;
         case (r.operation)
            tpq_pkg::OP_LOAD: begin
               if (a != 0) begin
                  d = int'(depth[b]) + 1;
                  if (d > 16383) d = 16383;
                  depth[a]     = d[13:0];
                  root_dist[a] = root_dist[b] + 34'(r.weight);
                  anc[a][0]    = b;
                  for (int i = 1; i < tpq_pkg::LEVELS; i++)
                     anc[a][i] = anc[anc[a][i-1]][i-1];
               end
            end
            tpq_pkg::OP_DIST: begin
               l = meet(a, b);
               e.path_weight = root_dist[a] + root_dist[b] - (root_dist[l] << 1);
               pending = {pending, e};
            end
            tpq_pkg::OP_KTH: begin
               l = meet(a, b);
               da = int'(depth[a]);
               db = int'(depth[b]);
               dl = int'(depth[l]);
               cnt = da + db - 2 * dl + 1;
               up_side = da - dl + 1;
               k = int'(r.position);
               if (k == 0 || k > cnt) e.error = 1'b1;
               else if (up_side >= k) e.kth_node = lift(a, da - k + 1);
               else e.kth_node = lift(b, dl + (k - up_side));
               pending = {pending, e};
            end
            default: ;
         endcase
      endfunction

      task check(tpq_pkg::rsp_type g);
         tpq_pkg::rsp_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected item %h", g));
            return;
         end
         e = pending.pop_front();
         checked++;
         if (g.path_weight !== e.path_weight)
            report($sformatf("path_weight %0d, want %0d", g.path_weight, e.path_weight));
         if (g.kth_node !== e.kth_node)
            report($sformatf("kth_node %0d, want %0d", g.kth_node, e.kth_node));
         if (g.error !== e.error)
            report($sformatf("error %b, want %b", g.error, e.error));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   tpq_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   tpq_pkg::rsp_type rsp_data;

   path_scoreboard sb = new();
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          cycles = 0;
   int          items_sent = 0;
   logic [13:0] pool[$];
   bit          loaded[tpq_pkg::NODES];

   tree_path_query DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (!reset) begin
         if (req_valid && !req_stall) sb.note(req_data);
         if (rsp_valid && !rsp_stall) sb.check(rsp_data);
      end
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   function automatic tpq_pkg::req_type mk(logic [1:0] op, logic [13:0] a, logic [13:0] b,
                                           logic [19:0] w, logic [13:0] p);
      tpq_pkg::req_type r;
      r.operation = op;
      r.node_a    = a;
      r.node_b    = b;
      r.weight    = w;
      r.position  = p;
      return r;
   endfunction

   task automatic send(tpq_pkg::req_type r);
      bit ok;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end while (!ok);
      if (r.operation == tpq_pkg::OP_LOAD && r.node_a != 0 && !loaded[r.node_a]) begin
         loaded[r.node_a] = 1'b1;
         pool = {pool, r.node_a};
      end
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic send_random();
      logic [13:0] a, b, p;
      int          sel, cnt;
      sel = $urandom_range(99);
      if (sel < 30 || pool.size() < 4) begin
         if ($urandom_range(9) == 0) a = pool[$urandom_range(pool.size() - 1)];
         else a = 14'($urandom_range(16383, 1));
         if ($urandom_range(1) == 0) b = pool[pool.size() - 1];
         else b = pool[$urandom_range(pool.size() - 1)];
         if (a == 0) a = 14'd1;
         if (a == b && !loaded[a]) b = 14'd0;
         send(mk(tpq_pkg::OP_LOAD, a, b, 20'($urandom), 14'($urandom)));
      end else if (sel < 32) begin
         send(mk(tpq_pkg::OP_LOAD, 14'd0, 14'($urandom), 20'($urandom), 14'($urandom)));
      end else if (sel < 34) begin
         send(mk(OP_SPARE, 14'($urandom), 14'($urandom), 20'($urandom), 14'($urandom)));
      end else begin
         a = pool[$urandom_range(pool.size() - 1)];
         b = pool[$urandom_range(pool.size() - 1)];
         if (sel < 64) begin
            send(mk(tpq_pkg::OP_DIST, a, b, 20'($urandom), 14'($urandom)));
         end else begin
            cnt = sb.path_nodes(a, b);
            case ($urandom_range(4))
               0:       p = 14'(cnt);
               1:       p = 14'(cnt + 1);
               2:       p = 14'($urandom);
               default: p = 14'($urandom_range(cnt + 1, 0));
            endcase
            send(mk(tpq_pkg::OP_KTH, a, b, 20'($urandom), p));
         end
      end
   endtask

   initial begin
      int cnt;
      int idle_set[4]  = '{0, 74, 0, 11};
      int stall_set[4] = '{0, 0, 74, 11};
      pool = {pool, 14'd0};
      loaded[0] = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two trees, extreme weights and node numbers, then distance and k-th queries
      send(mk(tpq_pkg::OP_LOAD, 14'd1, 14'd0, 20'hFFFFF, 14'd0));
      send(mk(tpq_pkg::OP_LOAD, 14'd2, 14'd1, 20'd0, 14'h3FFF));
      send(mk(tpq_pkg::OP_LOAD, 14'd3, 14'd2, 20'd12345, 14'd0));
      send(mk(tpq_pkg::OP_LOAD, 14'h3FFF, 14'd3, 20'hFFFFF, 14'd0));
      send(mk(tpq_pkg::OP_LOAD, 14'd8191, 14'd1, 20'd7, 14'd0));
      send(mk(tpq_pkg::OP_LOAD, 14'd100, 14'd0, 20'd5, 14'd0));
      send(mk(tpq_pkg::OP_LOAD, 14'd101, 14'd100, 20'h80000, 14'd0));
      send(mk(tpq_pkg::OP_LOAD, 14'd0, 14'd5, 20'd99, 14'd0));
      send(mk(OP_SPARE, 14'h3FFF, 14'h3FFF, 20'hFFFFF, 14'h3FFF));
      send(mk(tpq_pkg::OP_DIST, 14'h3FFF, 14'd8191, 20'd0, 14'd0));
      send(mk(tpq_pkg::OP_DIST, 14'h3FFF, 14'd101, 20'd0, 14'd0));
      send(mk(tpq_pkg::OP_DIST, 14'd3, 14'd3, 20'd0, 14'd0));
      send(mk(tpq_pkg::OP_DIST, 14'd0, 14'h3FFF, 20'd0, 14'd0));
      cnt = sb.path_nodes(14'h3FFF, 14'd8191);
      send(mk(tpq_pkg::OP_KTH, 14'h3FFF, 14'd8191, 20'd0, 14'd0));
      send(mk(tpq_pkg::OP_KTH, 14'h3FFF, 14'd8191, 20'd0, 14'd1));
      send(mk(tpq_pkg::OP_KTH, 14'h3FFF, 14'd8191, 20'd0, 14'd4));
      send(mk(tpq_pkg::OP_KTH, 14'h3FFF, 14'd8191, 20'd0, 14'(cnt)));
      send(mk(tpq_pkg::OP_KTH, 14'h3FFF, 14'd8191, 20'd0, 14'(cnt + 1)));
      send(mk(tpq_pkg::OP_KTH, 14'h3FFF, 14'd101, 20'd0, 14'd5));
      send(mk(tpq_pkg::OP_KTH, 14'd101, 14'h3FFF, 20'd0, 14'd3));
      send(mk(tpq_pkg::OP_KTH, 14'd0, 14'd0, 20'd0, 14'd1));
      send(mk(tpq_pkg::OP_KTH, 14'd3, 14'd3, 20'd0, 14'h3FFF));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_set[ph];
         stall_pct = stall_set[ph];
         for (int n = 0; n < 310; n++) begin
            send_random();
            if (n == 150 && ph == 1) drain();
         end
         drain();
      end
      stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run: %0d items sent, %0d results checked, %0d nodes in forest",
               items_sent, sb.checked, pool.size() - 1);
      $display("phases: free flow, sender idle, receiver stall, mixed");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
